// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define FJM_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the cycle after the antecedent, active during reset too
`define FJM_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/fjm_pkg.sv =====
// ----------------------------------------------------------------------------
// fjm_pkg
// shared widths and types of the facet jacobian and measure unit
// ----------------------------------------------------------------------------
package fjm_pkg;

    localparam int COORD_W = 24;
    localparam int JAC_W   = 25;
    localparam int PROD_W  = 50;
    localparam int CROSS_W = 51;
    localparam int SUM_W   = 100;
    localparam int ROOT_W  = 50;
    localparam int MEAS_W  = 34;
    localparam int FRAC_W  = 16;
    localparam int NUM_JAC = 6;
    localparam int NUM_CRS = 3;
    localparam int HI_W    = 25;
    localparam int LO_W    = 26;
    localparam int SQR_W   = 102;
    localparam int REM_W   = 52;
    // pipeline depth of the squaring section and the root section
    localparam int SQ_STAGES   = 3;
    localparam int ROOT_STAGES = ROOT_W;
    localparam int JAC_DELAY   = SQ_STAGES + ROOT_STAGES;
    localparam int IN_DATA_W   = 9 * COORD_W;
    // result fields packed, then padded with zeros to whole bytes
    localparam int OUT_FIELD_W = NUM_JAC * JAC_W + MEAS_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic {
        KIND_LINE     = 1'b0,
        KIND_TRIANGLE = 1'b1
    } t_kind;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [JAC_W-1:0]   t_jac;
    typedef logic        [CROSS_W-1:0] t_mag;
    typedef logic        [SUM_W-1:0]   t_sum;

    // pipeline control shared by all sections
    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

endpackage

// ===== rtl/fjm_front.sv =====
// ----------------------------------------------------------------------------
// fjm_front
// edge differences, cross products and cross magnitudes in three stages
// ----------------------------------------------------------------------------
module fjm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fjm_pkg::t_pipe_ctl   i_ctl,
    input  fjm_pkg::t_kind       i_kind,
    input  fjm_pkg::t_coord      i_node [9],
    output logic                 o_vld,
    output fjm_pkg::t_jac        o_jac [fjm_pkg::NUM_JAC],
    output fjm_pkg::t_mag        o_mag [fjm_pkg::NUM_CRS]
);

    logic                                 r_vld1, r_vld2, r_vld3;
    fjm_pkg::t_kind                       r_kind1, r_kind2;
    fjm_pkg::t_jac                        r_jac1 [fjm_pkg::NUM_JAC];
    fjm_pkg::t_jac                        r_jac2 [fjm_pkg::NUM_JAC];
    fjm_pkg::t_jac                        r_jac3 [fjm_pkg::NUM_JAC];
    logic signed [fjm_pkg::PROD_W-1:0]    r_prod [fjm_pkg::NUM_JAC];
    fjm_pkg::t_mag                        r_mag [fjm_pkg::NUM_CRS];
    fjm_pkg::t_jac                        n_jac [fjm_pkg::NUM_JAC];
    fjm_pkg::t_jac                        n_diff [fjm_pkg::NUM_JAC];
    logic signed [fjm_pkg::CROSS_W-1:0]   n_cross [fjm_pkg::NUM_CRS];
    fjm_pkg::t_mag                        n_mag [fjm_pkg::NUM_CRS];

    // edge differences; line mode keeps half of the first edge's x and y
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_diff[k]     = fjm_pkg::JAC_W'(i_node[3 + k]) - fjm_pkg::JAC_W'(i_node[k]);
            n_diff[3 + k] = fjm_pkg::JAC_W'(i_node[6 + k]) - fjm_pkg::JAC_W'(i_node[k]);
        end
        for (int k = 0; k < fjm_pkg::NUM_JAC; k++) begin
            n_jac[k] = (i_kind == fjm_pkg::KIND_TRIANGLE) ? n_diff[k] : '0;
        end
        if (i_kind == fjm_pkg::KIND_LINE) begin
            n_jac[0] = n_diff[0] >>> 1;
            n_jac[1] = n_diff[1] >>> 1;
        end
    end

    // cross terms; line mode feeds the scaled half edge instead
    always_comb begin
        if (r_kind2 == fjm_pkg::KIND_TRIANGLE) begin
            n_cross[0] = fjm_pkg::CROSS_W'(r_prod[0]) - fjm_pkg::CROSS_W'(r_prod[1]);
            n_cross[1] = fjm_pkg::CROSS_W'(r_prod[2]) - fjm_pkg::CROSS_W'(r_prod[3]);
            n_cross[2] = fjm_pkg::CROSS_W'(r_prod[4]) - fjm_pkg::CROSS_W'(r_prod[5]);
        end else begin
            n_cross[0] = fjm_pkg::CROSS_W'(r_jac2[0]) <<< fjm_pkg::FRAC_W;
            n_cross[1] = fjm_pkg::CROSS_W'(r_jac2[1]) <<< fjm_pkg::FRAC_W;
            n_cross[2] = '0;
        end
        for (int k = 0; k < fjm_pkg::NUM_CRS; k++) begin
            n_mag[k] = n_cross[k][fjm_pkg::CROSS_W-1] ? fjm_pkg::t_mag'(-n_cross[k])
                                                      : fjm_pkg::t_mag'(n_cross[k]);
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld1 <= i_ctl.vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    // data stages
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_kind1 <= i_kind;
            r_kind2 <= r_kind1;
            r_jac1  <= n_jac;
            r_jac2  <= r_jac1;
            r_jac3  <= r_jac2;
            r_prod[0] <= r_jac1[1] * r_jac1[5];
            r_prod[1] <= r_jac1[4] * r_jac1[2];
            r_prod[2] <= r_jac1[2] * r_jac1[3];
            r_prod[3] <= r_jac1[5] * r_jac1[0];
            r_prod[4] <= r_jac1[0] * r_jac1[4];
            r_prod[5] <= r_jac1[1] * r_jac1[3];
            r_mag   <= n_mag;
        end
    end

    assign o_vld = r_vld3;
    assign o_jac = r_jac3;
    assign o_mag = r_mag;

endmodule

// ===== rtl/fjm_square.sv =====
// ----------------------------------------------------------------------------
// fjm_square
// sum of three squared magnitudes from split partial products
// ----------------------------------------------------------------------------
module fjm_square (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fjm_pkg::t_pipe_ctl   i_ctl,
    input  fjm_pkg::t_mag        i_mag [fjm_pkg::NUM_CRS],
    output logic                 o_vld,
    output fjm_pkg::t_sum        o_sum
);

    logic                                 r_vld [fjm_pkg::SQ_STAGES];
    logic [2*fjm_pkg::HI_W-1:0]           r_hh [fjm_pkg::NUM_CRS];
    logic [fjm_pkg::HI_W+fjm_pkg::LO_W-1:0] r_hl [fjm_pkg::NUM_CRS];
    logic [2*fjm_pkg::LO_W-1:0]           r_ll [fjm_pkg::NUM_CRS];
    logic [fjm_pkg::SQR_W-1:0]            r_sq [fjm_pkg::NUM_CRS];
    fjm_pkg::t_sum                        r_sum;
    logic [fjm_pkg::SQR_W-1:0]            n_sq [fjm_pkg::NUM_CRS];
    logic [fjm_pkg::SQR_W-1:0]            n_sum;

    // recombine partial products: hi*hi<<52 + hi*lo<<27 + lo*lo
    always_comb begin
        for (int k = 0; k < fjm_pkg::NUM_CRS; k++) begin
            n_sq[k] = (fjm_pkg::SQR_W'(r_hh[k]) << (2 * fjm_pkg::LO_W))
                    + (fjm_pkg::SQR_W'(r_hl[k]) << (fjm_pkg::LO_W + 1))
                    + fjm_pkg::SQR_W'(r_ll[k]);
        end
        n_sum = r_sq[0] + r_sq[1] + r_sq[2];
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < fjm_pkg::SQ_STAGES; s++) r_vld[s] <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld[0] <= i_ctl.vld;
            for (int s = 1; s < fjm_pkg::SQ_STAGES; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // partial products, per-term squares, total
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int k = 0; k < fjm_pkg::NUM_CRS; k++) begin
                r_hh[k] <= i_mag[k][fjm_pkg::CROSS_W-1:fjm_pkg::LO_W]
                         * i_mag[k][fjm_pkg::CROSS_W-1:fjm_pkg::LO_W];
                r_hl[k] <= i_mag[k][fjm_pkg::CROSS_W-1:fjm_pkg::LO_W]
                         * i_mag[k][fjm_pkg::LO_W-1:0];
                r_ll[k] <= i_mag[k][fjm_pkg::LO_W-1:0] * i_mag[k][fjm_pkg::LO_W-1:0];
            end
            r_sq  <= n_sq;
            r_sum <= n_sum[fjm_pkg::SUM_W-1:0];
        end
    end

    assign o_vld = r_vld[fjm_pkg::SQ_STAGES-1];
    assign o_sum = r_sum;

endmodule

// ===== rtl/fjm_sqrt.sv =====
// ----------------------------------------------------------------------------
// fjm_sqrt
// pipelined floor square root, one root bit per stage
// ----------------------------------------------------------------------------
module fjm_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fjm_pkg::t_pipe_ctl          i_ctl,
    input  fjm_pkg::t_sum               i_rad,
    output logic                        o_vld,
    output logic [fjm_pkg::ROOT_W-1:0]  o_root
);

    logic                              r_vld  [fjm_pkg::ROOT_STAGES];
    logic [fjm_pkg::REM_W-1:0]         r_rem  [fjm_pkg::ROOT_STAGES];
    logic [fjm_pkg::ROOT_W-1:0]        r_root [fjm_pkg::ROOT_STAGES];
    fjm_pkg::t_sum                     r_rad  [fjm_pkg::ROOT_STAGES];
    logic [fjm_pkg::REM_W-1:0]         p_rem  [fjm_pkg::ROOT_STAGES];
    logic [fjm_pkg::ROOT_W-1:0]        p_root [fjm_pkg::ROOT_STAGES];
    fjm_pkg::t_sum                     p_rad  [fjm_pkg::ROOT_STAGES];
    logic [fjm_pkg::REM_W+1:0]         n_cur  [fjm_pkg::ROOT_STAGES];
    logic [fjm_pkg::REM_W+1:0]         n_trial[fjm_pkg::ROOT_STAGES];
    logic [fjm_pkg::REM_W-1:0]         n_rem  [fjm_pkg::ROOT_STAGES];
    logic [fjm_pkg::ROOT_W-1:0]        n_root [fjm_pkg::ROOT_STAGES];

    // stage inputs: first stage starts from zero
    always_comb begin
        p_rem[0]  = '0;
        p_root[0] = '0;
        p_rad[0]  = i_rad;
        for (int s = 1; s < fjm_pkg::ROOT_STAGES; s++) begin
            p_rem[s]  = r_rem[s-1];
            p_root[s] = r_root[s-1];
            p_rad[s]  = r_rad[s-1];
        end
    end

    // one restoring step per stage, independent across stages
    always_comb begin
        for (int s = 0; s < fjm_pkg::ROOT_STAGES; s++) begin
            n_cur[s]   = {p_rem[s], p_rad[s][fjm_pkg::SUM_W-1 -: 2]};
            n_trial[s] = {2'b00, p_root[s], 2'b01};
            if (n_cur[s] >= n_trial[s]) begin
                n_rem[s]  = fjm_pkg::REM_W'(n_cur[s] - n_trial[s]);
                n_root[s] = {p_root[s][fjm_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[s]  = n_cur[s][fjm_pkg::REM_W-1:0];
                n_root[s] = {p_root[s][fjm_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < fjm_pkg::ROOT_STAGES; s++) r_vld[s] <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld[0] <= i_ctl.vld;
            for (int s = 1; s < fjm_pkg::ROOT_STAGES; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    // data stages
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int s = 0; s < fjm_pkg::ROOT_STAGES; s++) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_rad[s]  <= p_rad[s] << 2;
            end
        end
    end

    assign o_vld  = r_vld[fjm_pkg::ROOT_STAGES-1];
    assign o_root = r_root[fjm_pkg::ROOT_STAGES-1];

endmodule

// ===== rtl/facet_jacobian_and_measure_unit.sv =====
// ----------------------------------------------------------------------------
// facet_jacobian_and_measure_unit
// jacobian and measure of a line or triangle mesh facet
// ----------------------------------------------------------------------------
// Takes one facet item per cycle while the output is not stalled, and
// offers its 3x2 jacobian and measure through 57 register stages (3
// difference/cross stages, 3 squaring stages, 50 square root stages at one
// root bit each, one output register). The whole pipeline advances together
// whenever the output register is empty or being taken, so a stall holds
// every item in place. i_cfg_we writes the facet kind (0 line, 1 triangle,
// reset 1); write it only while idle.
module facet_jacobian_and_measure_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_wdata,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // node0_x, node0_y, node0_z, node1_x, node1_y, node1_z, node2_x, node2_y, node2_z
    input  logic [fjm_pkg::IN_DATA_W-1:0]        i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // dx_dxi, dy_dxi, dz_dxi, dx_deta, dy_deta, dz_deta, measure, zero pad
    output logic [fjm_pkg::OUT_DATA_W-1:0]       o_m_tdata
);

    fjm_pkg::t_kind                  r_kind;
    logic                            r_ovld;
    logic [fjm_pkg::OUT_FIELD_W-1:0] r_odata;
    fjm_pkg::t_jac                   r_jdly [fjm_pkg::JAC_DELAY][fjm_pkg::NUM_JAC];
    fjm_pkg::t_pipe_ctl              ctl_in, ctl_sq, ctl_rt;
    fjm_pkg::t_coord                 node [9];
    logic                            fr_vld, sq_vld, rt_vld;
    fjm_pkg::t_jac                   fr_jac [fjm_pkg::NUM_JAC];
    fjm_pkg::t_mag                   fr_mag [fjm_pkg::NUM_CRS];
    fjm_pkg::t_sum                   sq_sum;
    logic [fjm_pkg::ROOT_W-1:0]      rt_root;
    logic                            en;

    // global advance
    assign en         = !r_ovld || i_m_tready;
    assign o_s_tready = en;
    assign ctl_in     = '{en: en, vld: i_s_tvalid};
    assign ctl_sq     = '{en: en, vld: fr_vld};
    assign ctl_rt     = '{en: en, vld: sq_vld};

    // unpack input item
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            node[k] = i_s_tdata[k*fjm_pkg::COORD_W +: fjm_pkg::COORD_W];
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= fjm_pkg::KIND_TRIANGLE;
        end else if (i_cfg_we) begin
            r_kind <= fjm_pkg::t_kind'(i_cfg_wdata);
        end
    end

    fjm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_in),
        .i_kind  (r_kind),
        .i_node  (node),
        .o_vld   (fr_vld),
        .o_jac   (fr_jac),
        .o_mag   (fr_mag)
    );

    fjm_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_sq),
        .i_mag   (fr_mag),
        .o_vld   (sq_vld),
        .o_sum   (sq_sum)
    );

    fjm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_rt),
        .i_rad   (sq_sum),
        .o_vld   (rt_vld),
        .o_root  (rt_root)
    );

    // jacobian travels beside the measure pipeline
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_jdly[0] <= fr_jac;
            for (int s = 1; s < fjm_pkg::JAC_DELAY; s++) r_jdly[s] <= r_jdly[s-1];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= rt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < fjm_pkg::NUM_JAC; k++) begin
                r_odata[k*fjm_pkg::JAC_W +: fjm_pkg::JAC_W] <=
                    r_jdly[fjm_pkg::JAC_DELAY-1][k];
            end
            r_odata[fjm_pkg::NUM_JAC*fjm_pkg::JAC_W +: fjm_pkg::MEAS_W] <=
                rt_root[fjm_pkg::ROOT_W-1:fjm_pkg::FRAC_W];
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = fjm_pkg::OUT_DATA_W'(r_odata);

endmodule

// ===== rtl/fjm_checker.sv =====
// ----------------------------------------------------------------------------
// fjm_checker
// port level checks of the facet jacobian and measure unit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fjm_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_s_tready,
    input  logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [fjm_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    // a held result keeps its value
    `FJM_ASSERT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, ##1 $stable(o_m_tdata))

    // input side is never blocked while the output register is empty
    `FJM_ASSERT(a_ready_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready)

    // input side follows the output stall exactly
    `FJM_ASSERT(a_ready_stall, i_clk, i_rst_n, o_m_tvalid, o_s_tready == i_m_tready)

    // no result right after reset
    `FJM_ASSERT_NEXT(a_reset_quiet, i_clk, !i_rst_n, !o_m_tvalid)

endmodule

bind facet_jacobian_and_measure_unit fjm_checker u_fjm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== test/facet_jacobian_and_measure_unit_tb.sv =====
// ----------------------------------------------------------------------------
// facet_jacobian_and_measure_unit_tb
// self-checking bench for the facet jacobian and measure unit
// ----------------------------------------------------------------------------
// Streams facets in line and triangle mode through the unit and compares
// every returned jacobian and measure with a behavioral predictor or with
// hand-worked values. A short table of hand-picked facets comes first,
// then random facets in phases of alternating facet kind, with random gaps
// on both sides, one stretch with no gaps, and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module facet_jacobian_and_measure_unit_tb;

    localparam int LATENCY    = 57;
    localparam int SETTLE     = LATENCY + 8;
    localparam int STALL_LIM  = 4000;
    localparam int PHASE_LEN  = 325;
    localparam int NUM_PHASES = 6;
    localparam int HOLD_PHASE = 2;
    localparam int HOLD_ITEM  = 50;
    localparam int HOLD_LEN   = 400;

    typedef fjm_pkg::t_coord t_nodes [9];

    typedef struct {
        fjm_pkg::t_jac                jac [fjm_pkg::NUM_JAC];
        logic [fjm_pkg::MEAS_W-1:0]   meas;
    } t_facet_res;

    typedef struct {
        fjm_pkg::t_kind kind;
        t_nodes         nodes;
        bit             typed;
        t_facet_res     res;
    } t_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic                           i_cfg_wdata;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [fjm_pkg::IN_DATA_W-1:0]  i_s_tdata;
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [fjm_pkg::OUT_DATA_W-1:0] o_m_tdata;

    t_facet_res     pending_res [$];
    t_row           facet_table [$];
    fjm_pkg::t_kind cur_kind;
    bit             no_gaps;
    bit             hold_req;
    int             fail_cnt;
    string          jac_name [fjm_pkg::NUM_JAC] =
        '{"dx_dxi", "dy_dxi", "dz_dxi", "dx_deta", "dy_deta", "dz_deta"};

    facet_jacobian_and_measure_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // square of a signed value, exact
    function automatic logic [127:0] square_of(logic signed [51:0] v);
        logic signed [127:0] w;
        w = v;
        if (w < 0) w = -w;
        return w * w;
    endfunction

    // floor square root, one bit per step
    function automatic logic [63:0] floor_root(logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  cand;
        logic [127:0] cw;
        r = '0;
        for (int b = 51; b >= 0; b--) begin
            cand = r | (64'd1 << b);
            cw   = cand;
            if (cw * cw <= s) r = cand;
        end
        return r;
    endfunction

    // jacobian and measure of one facet
    function automatic t_facet_res facet_measure(fjm_pkg::t_kind kind, t_nodes n);
        t_facet_res         r;
        logic signed [24:0] d [fjm_pkg::NUM_JAC];
        logic signed [51:0] c0, c1, c2;
        logic [127:0]       s;
        for (int i = 0; i < fjm_pkg::NUM_JAC; i++) begin
            d[i] = $signed({n[i + 3][23], n[i + 3]})
                 - $signed({n[i % 3][23], n[i % 3]});
        end
        for (int i = 0; i < fjm_pkg::NUM_JAC; i++) r.jac[i] = '0;
        if (kind == fjm_pkg::KIND_LINE) begin
            r.jac[0] = d[0] >>> 1;
            r.jac[1] = d[1] >>> 1;
            s = square_of(r.jac[0]) + square_of(r.jac[1]);
            r.meas = 34'(floor_root(s));
        end else begin
            for (int i = 0; i < fjm_pkg::NUM_JAC; i++) r.jac[i] = d[i];
            c0 = d[1] * d[5] - d[4] * d[2];
            c1 = d[2] * d[3] - d[5] * d[0];
            c2 = d[0] * d[4] - d[1] * d[3];
            s = square_of(c0) + square_of(c1) + square_of(c2);
            r.meas = 34'(floor_root(s) >> 16);
        end
        return r;
    endfunction

    function automatic t_facet_res line_res(int j0, int j1, longint m);
        t_facet_res r;
        for (int i = 0; i < fjm_pkg::NUM_JAC; i++) r.jac[i] = '0;
        r.jac[0] = fjm_pkg::t_jac'(j0);
        r.jac[1] = fjm_pkg::t_jac'(j1);
        r.meas   = 34'(m);
        return r;
    endfunction

    function automatic fjm_pkg::t_coord rand_coord();
        case ($urandom_range(0, 7))
            0: return 24'sh800000;
            1: return 24'sh7fffff;
            2: return fjm_pkg::t_coord'($urandom_range(0, 511)) - 24'sd256;
            default: return fjm_pkg::t_coord'($urandom);
        endcase
    endfunction

    task automatic add_row(fjm_pkg::t_kind kind, t_nodes n, bit typed, t_facet_res res);
        t_row row;
        row.kind  = kind;
        row.nodes = n;
        row.typed = typed;
        row.res   = res;
        facet_table.push_back(row);
    endtask

    // one facet offered until taken; starts and ends at a falling edge
    task automatic send_facet(t_nodes n, bit typed, t_facet_res res);
        logic [fjm_pkg::IN_DATA_W-1:0] data;
        while (!no_gaps && $urandom_range(0, 99) < 37) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        for (int i = 0; i < 9; i++) data[i*fjm_pkg::COORD_W +: fjm_pkg::COORD_W] = n[i];
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_res.push_back(typed ? res : facet_measure(cur_kind, n));
        @(negedge i_clk);
    endtask

    // drain the pipeline, then write the facet kind
    task automatic set_kind(fjm_pkg::t_kind kind);
        i_s_tvalid <= 1'b0;
        while (pending_res.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= kind;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_kind = kind;
        @(negedge i_clk);
    endtask

    // output side: random gaps and one long hold once requested
    initial begin
        int hold_cnt;
        bit hold_taken;
        hold_cnt   = 0;
        hold_taken = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_cnt   = HOLD_LEN;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= no_gaps || ($urandom_range(0, 99) >= 37);
            end
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_facet_res    exp_res;
        fjm_pkg::t_jac got_jac;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_res.size() == 0) begin
                $error("unexpected result item");
                fail_cnt++;
            end else begin
                exp_res = pending_res.pop_front();
                for (int i = 0; i < fjm_pkg::NUM_JAC; i++) begin
                    got_jac = o_m_tdata[i*fjm_pkg::JAC_W +: fjm_pkg::JAC_W];
                    if (got_jac !== exp_res.jac[i]) begin
                        $error("%s expected %0d got %0d",
                               jac_name[i], exp_res.jac[i], got_jac);
                        fail_cnt++;
                    end
                end
                if (o_m_tdata[fjm_pkg::NUM_JAC*fjm_pkg::JAC_W +: fjm_pkg::MEAS_W]
                        !== exp_res.meas) begin
                    $error("measure expected %0d got %0d", exp_res.meas,
                           o_m_tdata[fjm_pkg::NUM_JAC*fjm_pkg::JAC_W +: fjm_pkg::MEAS_W]);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    initial begin
        int idle_cyc;
        idle_cyc = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cyc = 0;
            end else begin
                idle_cyc++;
            end
            if (idle_cyc >= STALL_LIM) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        t_nodes          n;
        t_facet_res      none;
        fjm_pkg::t_coord mn, mx;
        mn = 24'sh800000;
        mx = 24'sh7fffff;
        none = line_res(0, 0, 0);
        fail_cnt    = 0;
        no_gaps     = 1'b0;
        hold_req    = 1'b0;
        cur_kind    = fjm_pkg::KIND_TRIANGLE;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;

        // triangle facets under the reset kind
        n = '{default: 0};
        add_row(fjm_pkg::KIND_TRIANGLE, n, 1'b1, none);
        n = '{mn, mn, mn, mx, mx, mx, mn, mn, mn};
        add_row(fjm_pkg::KIND_TRIANGLE, n, 1'b0, none);
        n = '{0, 0, 0, mx, 0, 0, 0, mx, 0};
        add_row(fjm_pkg::KIND_TRIANGLE, n, 1'b0, none);
        n = '{mx, mx, mx, mn, mx, mx, mx, mn, mx};
        add_row(fjm_pkg::KIND_TRIANGLE, n, 1'b0, none);
        n = '{mn, mx, mn, mx, mn, mx, mx, mx, mn};
        add_row(fjm_pkg::KIND_TRIANGLE, n, 1'b0, none);
        n = '{mx, mn, mx, mn, mx, mn, mn, mn, mx};
        add_row(fjm_pkg::KIND_TRIANGLE, n, 1'b0, none);
        // collinear corners give a zero area
        n = '{0, 0, 0, 100, 200, 300, 200, 400, 600};
        add_row(fjm_pkg::KIND_TRIANGLE, n, 1'b0, none);
        n = '{-5, 7, -9, 65536, 3, 1, -2, 65536, -70000};
        add_row(fjm_pkg::KIND_TRIANGLE, n, 1'b0, none);
        // line facets: z and third corner ignored
        n = '{default: 0};
        add_row(fjm_pkg::KIND_LINE, n, 1'b1, none);
        n = '{0, 0, mx, 2, 0, mn, mx, mn, mx};
        add_row(fjm_pkg::KIND_LINE, n, 1'b1, line_res(1, 0, 1));
        // odd negative difference rounds down
        n = '{0, 0, 0, -1, 0, 0, 0, 0, 0};
        add_row(fjm_pkg::KIND_LINE, n, 1'b1, line_res(-1, 0, 1));
        n = '{0, 0, 0, 6, 8, 0, 0, 0, 0};
        add_row(fjm_pkg::KIND_LINE, n, 1'b1, line_res(3, 4, 5));
        n = '{mx, mx, 0, mn, mn, 0, 0, 0, 0};
        add_row(fjm_pkg::KIND_LINE, n, 1'b0, none);
        n = '{mn, mn, mx, mx, mx, mn, mn, mx, mn};
        add_row(fjm_pkg::KIND_LINE, n, 1'b0, none);
        n = '{mn, mx, 0, mx, mn, 0, 0, 0, 0};
        add_row(fjm_pkg::KIND_LINE, n, 1'b0, none);
        n = '{3, -3, 0, -4, 4, 0, 0, 0, 0};
        add_row(fjm_pkg::KIND_LINE, n, 1'b0, none);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (facet_table[r]) begin
            if (facet_table[r].kind != cur_kind) set_kind(facet_table[r].kind);
            send_facet(facet_table[r].nodes, facet_table[r].typed, facet_table[r].res);
        end

        // random phases, kind alternating; one phase with no gaps
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_kind((p % 2 == 0) ? fjm_pkg::KIND_TRIANGLE : fjm_pkg::KIND_LINE);
            no_gaps = (p == 3);
            for (int k = 0; k < PHASE_LEN; k++) begin
                // long output hold while facets keep coming
                if (p == HOLD_PHASE && k == HOLD_ITEM) hold_req = 1'b1;
                foreach (n[i]) n[i] = rand_coord();
                send_facet(n, 1'b0, none);
            end
            no_gaps = 1'b0;
        end
        i_s_tvalid <= 1'b0;

        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_cnt == 0 && pending_res.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
